[sv/dsa_pkg.sv]
// ----------------------------------------------------------------------------
// dsa_pkg
// Shared constants, codes and controller/datapath types of the depth shift
// anaglyph block.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int MAX_ROW_WIDTH = 2048;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int CNT_W         = COL_W + 1;
    localparam int ADDR_W        = COL_W + 1;
    localparam int MEM_DEPTH     = 2 * MAX_ROW_WIDTH;
    localparam int WIDTH_W       = 12;
    localparam int CFG_W         = 12;
    localparam int CMP_W         = (CNT_W > WIDTH_W) ? CNT_W : WIDTH_W;

    // rounded quotient (2*mag + k) / (2*k)
    localparam int DIV_W     = 17;
    localparam int DVS_W     = 9;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int TGT_W     = ((CNT_W > DIV_W) ? CNT_W : DIV_W) + 1;

    localparam logic [21:0] LUMA_R   = 22'd4899;
    localparam logic [21:0] LUMA_G   = 22'd9617;
    localparam logic [21:0] LUMA_B   = 22'd1868;
    localparam logic [21:0] LUMA_RND = 22'd8192;

    typedef enum logic [1:0] {
        CFG_COEF  = 2'd0,
        CFG_REF   = 2'd1,
        CFG_GRAY  = 2'd2,
        CFG_WIDTH = 2'd3
    } t_cfg_addr;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EMIT_RD,
        S_EMIT_WR,
        S_PREP,
        S_DIVGO,
        S_DIV,
        S_OWN,
        S_TGT
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic accept;
        logic emit_rd;
        logic emit_load;
        logic prep;
        logic div_start;
        logic own_wr;
        logic tgt_wr;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic pending;
        logic is_flush;
        logic out_free;
        logic div_done;
    } t_status;

endpackage

[sv/dsa_div.sv]
// ----------------------------------------------------------------------------
// dsa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [dsa_pkg::DIV_W-1:0]  i_dividend,
    input  logic [dsa_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [dsa_pkg::DIV_W-1:0]  o_quotient
);
    import dsa_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DIV_W-1:0]     r_quo;
    logic [DVS_W:0]       trial;
    logic [DVS_W:0]       diff;
    logic                 ge;

    always_comb begin
        trial = {r_rem, r_quo[DIV_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= DIV_CNT_W'(DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_done     = (r_cnt == '0) && !i_start;
    assign o_quotient = r_quo;

endmodule

[sv/dsa_dp.sv]
// ----------------------------------------------------------------------------
// dsa_dp
// Datapath: config registers, row buffers, written flags, shift arithmetic
// and the output register.
// ----------------------------------------------------------------------------
module dsa_dp (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  dsa_pkg::t_cmd           i_cmd,
    output dsa_pkg::t_status        o_status,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_addr,
    input  logic [dsa_pkg::CFG_W-1:0] i_cfg_wdata,
    input  logic [31:0]             i_in_data,
    input  logic                    i_in_user,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [23:0]             o_out_data,
    output logic                    o_out_last
);
    import dsa_pkg::*;

    logic [7:0]         r_coef;
    logic [7:0]         r_ref;
    logic               r_gray;
    logic [WIDTH_W-1:0] r_width;

    logic               r_flush;
    logic [7:0]         r_red, r_grn, r_blu, r_dep;
    logic [7:0]         r_pr, r_pg, r_pb;
    logic               r_sign;
    logic [15:0]        r_mag;
    logic               r_flag_q;

    logic [CNT_W-1:0]   r_in_col;
    logic [CNT_W-1:0]   r_out_col;
    logic               r_bank;
    logic               r_pending;
    logic [COL_W-1:0]   r_clr_addr;

    logic [7:0]         r_rd_red;
    logic [15:0]        r_rd_gb;
    logic               r_rd_last;

    logic               r_out_valid;
    logic [7:0]         r_out_red;
    logic [15:0]        r_out_gb;
    logic               r_out_last;

    logic               r_flag_mem [MAX_ROW_WIDTH];
    logic [15:0]        r_gb_mem   [MEM_DEPTH];
    logic [7:0]         r_red_mem  [MEM_DEPTH];

    logic [CNT_W-1:0]   w;
    logic [CNT_W-1:0]   col_in;
    logic [COL_W-1:0]   col_a;
    logic [ADDR_W-1:0]  own_addr;
    logic [ADDR_W-1:0]  emit_addr;
    logic               emit_last;
    logic               in_last;
    logic [7:0]         k;
    logic [7:0]         absdiff;
    logic [21:0]        ysum;
    logic [DIV_W-1:0]   dividend;
    logic [DIV_W-1:0]   div_q;
    logic [DIV_W-1:0]   q;
    logic               div_done;
    logic [TGT_W-1:0]   tsum;
    logic               tgt_ok;
    logic [COL_W-1:0]   t_a;
    logic               flag_we;
    logic [COL_W-1:0]   flag_wa;
    logic               flag_wd;
    logic               gb_we;
    logic [ADDR_W-1:0]  gb_wa;
    logic               out_free;

    always_comb begin
        if (r_width == '0) begin
            w = CNT_W'(1);
        end else if (CMP_W'(r_width) > CMP_W'(MAX_ROW_WIDTH)) begin
            w = CNT_W'(MAX_ROW_WIDTH);
        end else begin
            w = CNT_W'(r_width);
        end
        col_in    = (r_in_col >= w) ? (w - 1'b1) : r_in_col;
        col_a     = col_in[COL_W-1:0];
        own_addr  = {r_bank, col_a};
        emit_addr = {~r_bank, r_out_col[COL_W-1:0]};
        emit_last = ({1'b0, r_out_col} + 1'b1) >= {1'b0, w};
        in_last   = ({1'b0, col_in} + 1'b1) >= {1'b0, w};

        k       = 8'd255 - r_ref;
        absdiff = (r_dep > k) ? (r_dep - k) : (k - r_dep);
        ysum    = 22'(r_red) * LUMA_R + 22'(r_grn) * LUMA_G
                + 22'(r_blu) * LUMA_B + LUMA_RND;

        dividend = {r_mag, 1'b0} + DIV_W'(k);
        q        = (k == '0) ? '0 : div_q;
        if (r_sign) begin
            tgt_ok = TGT_W'(q) <= TGT_W'(col_in);
            tsum   = TGT_W'(col_in) - TGT_W'(q);
        end else begin
            tsum   = TGT_W'(col_in) + TGT_W'(q);
            tgt_ok = tsum < TGT_W'(w);
        end
        t_a = tsum[COL_W-1:0];

        // a flag only matters for columns still ahead in this row
        flag_we = 1'b0;
        flag_wa = col_a;
        flag_wd = 1'b0;
        if (i_cmd.clr_step) begin
            flag_we = 1'b1;
            flag_wa = r_clr_addr;
        end else if (i_cmd.own_wr) begin
            flag_we = 1'b1;
        end else if (i_cmd.tgt_wr && tgt_ok && !r_sign && (q != '0)) begin
            flag_we = 1'b1;
            flag_wa = t_a;
            flag_wd = 1'b1;
        end

        gb_we = 1'b0;
        gb_wa = own_addr;
        if (i_cmd.own_wr && !r_flag_q) begin
            gb_we = 1'b1;
        end else if (i_cmd.tgt_wr && tgt_ok) begin
            gb_we = 1'b1;
            gb_wa = {r_bank, t_a};
        end

        out_free = !r_out_valid || i_out_ready;
    end

    dsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  ({k, 1'b0}),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            r_flag_mem[flag_wa] <= flag_wd;
        end
        if (i_cmd.prep) begin
            r_flag_q <= r_flag_mem[col_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (gb_we) begin
            r_gb_mem[gb_wa] <= {r_pg, r_pb};
        end
        if (i_cmd.emit_rd) begin
            r_rd_gb <= r_gb_mem[emit_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.own_wr) begin
            r_red_mem[own_addr] <= r_pr;
        end
        if (i_cmd.emit_rd) begin
            r_rd_red <= r_red_mem[emit_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_flush <= i_in_user;
            r_red   <= i_in_data[7:0];
            r_grn   <= i_in_data[15:8];
            r_blu   <= i_in_data[23:16];
            r_dep   <= i_in_data[31:24];
        end
        if (i_cmd.prep) begin
            r_pr   <= r_gray ? ysum[21:14] : r_red;
            r_pg   <= r_gray ? ysum[21:14] : r_grn;
            r_pb   <= r_gray ? ysum[21:14] : r_blu;
            r_sign <= r_dep > k;
            r_mag  <= 16'(absdiff) * 16'(r_coef);
        end
        if (i_cmd.emit_rd) begin
            r_rd_last <= emit_last;
        end
        if (i_cmd.emit_load) begin
            r_out_red  <= r_rd_red;
            r_out_gb   <= r_rd_gb;
            r_out_last <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef      <= '0;
            r_ref       <= '0;
            r_gray      <= 1'b0;
            r_width     <= WIDTH_W'(2048);
            r_in_col    <= '0;
            r_out_col   <= '0;
            r_bank      <= 1'b0;
            r_pending   <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_COEF:  r_coef  <= i_cfg_wdata[7:0];
                    CFG_REF:   r_ref   <= i_cfg_wdata[7:0];
                    CFG_GRAY:  r_gray  <= i_cfg_wdata[0];
                    CFG_WIDTH: r_width <= i_cfg_wdata[WIDTH_W-1:0];
                    default:   r_gray  <= r_gray;
                endcase
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.emit_rd) begin
                if (emit_last) begin
                    r_out_col <= '0;
                    r_pending <= 1'b0;
                end else begin
                    r_out_col <= r_out_col + 1'b1;
                end
            end else if (i_cmd.tgt_wr) begin
                if (in_last) begin
                    r_in_col  <= '0;
                    r_bank    <= ~r_bank;
                    r_pending <= 1'b1;
                    r_out_col <= '0;
                end else begin
                    r_in_col <= col_in + 1'b1;
                end
            end
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.clr_last = (r_clr_addr == COL_W'(MAX_ROW_WIDTH - 1));
    assign o_status.pending  = r_pending;
    assign o_status.is_flush = r_flush;
    assign o_status.out_free = out_free;
    assign o_status.div_done = div_done;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_gb[7:0], r_out_gb[15:8], r_out_red};
    assign o_out_last  = r_out_last;

    a_emit_needs_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_rd |-> r_pending)
        else $error("emission without a pending row");

    a_row_end_swaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tgt_wr && in_last) |=> (r_pending && (r_out_col == '0)
            && (r_in_col == '0)))
        else $error("row end did not make the row pending");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_load |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

[sv/dsa_ctrl.sv]
// ----------------------------------------------------------------------------
// dsa_ctrl
// Sequencer: flag clearing pass, pending-row emission, shift computation
// and row buffer writes, one item at a time.
// ----------------------------------------------------------------------------
module dsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  dsa_pkg::t_status  i_status,
    output dsa_pkg::t_cmd     o_cmd
);
    import dsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                if (i_status.pending) begin
                    o_cmd.emit_rd = 1'b1;
                    n_state       = S_EMIT_WR;
                end else if (i_status.is_flush) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_EMIT_WR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = i_status.is_flush ? S_IDLE : S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) n_state = S_OWN;
            end
            S_OWN: begin
                o_cmd.own_wr = 1'b1;
                n_state      = S_TGT;
            end
            S_TGT: begin
                o_cmd.tgt_wr = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[sv/depth_shift_anaglyph.sv]
// ----------------------------------------------------------------------------
// depth_shift_anaglyph
// Red/cyan anaglyph by depth-based horizontal pixel shift, rows emitted one
// row late from double-buffered row memories.
// ----------------------------------------------------------------------------
// pixel item: accept, emission of a pending pixel if any, preparation, the
//   17-step rounding divider, then the own-column and target-column writes
// flush item: accept and, if a row is pending, emission of one of its pixels
// output register frees the input side while a result waits
// reset (synchronous, active low) starts a flag clearing pass over all
//   MAX_ROW_WIDTH (2048) flags before the first item is taken
module depth_shift_anaglyph (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // red_in, green_in, blue_in, depth_in
    input  logic        s_axis_tuser,   // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red_out, green_out, blue_out
    output logic        m_axis_tlast,   // row_end
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [dsa_pkg::CFG_W-1:0] i_cfg_wdata
);
    import dsa_pkg::*;

    t_cmd    cmd;
    t_status status;

    dsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    dsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
